### hw/rtl/bp3d_pkg.sv
package bp3d_pkg;

    localparam int RANK_W      = 30;
    localparam int PROC_W      = 11;
    localparam int PT_W        = 16;
    localparam int PLANE_W     = 2 * PROC_W;
    localparam int COORD_W     = 10;
    localparam int CNT_W       = 17;
    localparam int GH_W        = 4;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 136;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 16;

    // limits tied to PROC_W and PT_W above
    localparam int MAX_PROCS_PER_AXIS = 1024;
    localparam int MAX_POINTS         = 65535;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_X_PROCS  = 3'd0,
        REG_Y_PROCS  = 3'd1,
        REG_Z_PROCS  = 3'd2,
        REG_X_POINTS = 3'd3,
        REG_Y_POINTS = 3'd4,
        REG_Z_POINTS = 3'd5,
        REG_GHOST    = 3'd6,
        REG_SYM_X    = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic [PROC_W-1:0] procs;
        logic [GH_W-1:0]   ghost;
        logic              sym;
    } axis_cfg_t;

endpackage

### hw/rtl/bp3d_div_cell.sv
module bp3d_div_cell
    import bp3d_pkg::*;
#(
    parameter int NW = 30,
    parameter int DW = 22
) (
    input  logic          aclk,
    input  logic          en,
    input  logic [DW-1:0] den,
    input  logic [DW-1:0] rem_in,
    input  logic [NW-1:0] num_in,
    input  logic [NW-1:0] quo_in,
    output logic [DW-1:0] rem_out,
    output logic [NW-1:0] num_out,
    output logic [NW-1:0] quo_out
);

    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;
    logic [DW-1:0] rem_reg, rem_next;
    logic [NW-1:0] num_reg, num_next;
    logic [NW-1:0] quo_reg, quo_next;

    // one restoring step: bring down the next dividend bit, subtract if it fits
    always_comb begin
        trial    = {rem_in, num_in[NW-1]};
        ge       = (trial >= {1'b0, den});
        diff     = trial - {1'b0, den};
        rem_next = ge ? diff[DW-1:0] : trial[DW-1:0];
        num_next = {num_in[NW-2:0], 1'b0};
        quo_next = {quo_in[NW-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg <= rem_next;
            num_reg <= num_next;
            quo_reg <= quo_next;
        end
    end

    assign rem_out = rem_reg;
    assign num_out = num_reg;
    assign quo_out = quo_reg;

endmodule

### hw/rtl/bp3d_divider.sv
module bp3d_divider
    import bp3d_pkg::*;
#(
    parameter int LANES = 1,
    parameter int NW    = 30,
    parameter int DW    = 22
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      en,
    input  logic                      vld_in,
    input  logic [LANES-1:0][NW-1:0]  num_in,
    input  logic [LANES-1:0][DW-1:0]  den,
    output logic                      vld_out,
    output logic [LANES-1:0][NW-1:0]  quo_out,
    output logic [LANES-1:0][DW-1:0]  rem_out
);

    logic [LANES-1:0][NW:0][DW-1:0] rem_c;
    logic [LANES-1:0][NW:0][NW-1:0] num_c;
    logic [LANES-1:0][NW:0][NW-1:0] quo_c;
    logic [NW-1:0]                  vld_reg;

    for (genvar l = 0; l < LANES; l++) begin : g_lane
        assign rem_c[l][0] = '0;
        assign num_c[l][0] = num_in[l];
        assign quo_c[l][0] = '0;
        for (genvar k = 0; k < NW; k++) begin : g_cell
            bp3d_div_cell #(.NW(NW), .DW(DW)) u_cell (
                .aclk    (aclk),
                .en      (en),
                .den     (den[l]),
                .rem_in  (rem_c[l][k]),
                .num_in  (num_c[l][k]),
                .quo_in  (quo_c[l][k]),
                .rem_out (rem_c[l][k+1]),
                .num_out (num_c[l][k+1]),
                .quo_out (quo_c[l][k+1])
            );
        end
        assign quo_out[l] = quo_c[l][NW];
        assign rem_out[l] = rem_c[l][NW];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NW-2:0], vld_in};
        end
    end

    assign vld_out = vld_reg[NW-1];

endmodule

### hw/rtl/bp3d_axis.sv
module bp3d_axis
    import bp3d_pkg::*;
(
    input  logic              aclk,
    input  logic              en,
    input  axis_cfg_t         cfg,
    input  logic [PT_W-1:0]   q,
    input  logic [PROC_W-1:0] r,
    input  logic [PROC_W-1:0] me,
    output logic [CNT_W-1:0]  cnt,
    output logic [CNT_W-1:0]  org,
    output logic              sym_err
);

    logic                odd_mid, err_next;
    logic [PROC_W-1:0]   h, mid, top_start, lo, hi, add_next;
    logic                in_top, is_mid, past_mid, extra_next;
    logic [PT_W+PROC_W-1:0] prod;
    logic                first_next, lastn_next;

    logic [CNT_W-1:0]    prod_reg;
    logic [PT_W-1:0]     q_reg;
    logic [PROC_W-1:0]   add_reg;
    logic                extra_reg, err_reg, first_reg, lastn_reg;

    logic [CNT_W-1:0]    g, g_lo, g_hi;

    always_comb begin
        err_next   = cfg.sym && r[0] && !cfg.procs[0];
        odd_mid    = cfg.sym && r[0];
        // plain split is the symmetric one with no upper block and no middle node
        h          = cfg.sym ? (r >> 1) : r;
        mid        = cfg.procs >> 1;
        top_start  = cfg.procs - h;
        in_top     = cfg.sym && (me >= top_start);
        is_mid     = odd_mid && (me == mid);
        past_mid   = odd_mid && (me > mid);
        extra_next = (me < h) || in_top || is_mid;
        lo         = (me < h) ? me : h;
        hi         = (cfg.sym && (me > top_start)) ? (me - top_start) : '0;
        add_next   = lo + hi + PROC_W'(past_mid);
        prod       = q * me;
        first_next = (me == '0);
        lastn_next = ({1'b0, me} + (PROC_W+1)'(1)) < {1'b0, cfg.procs};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg  <= prod[CNT_W-1:0];
            q_reg     <= q;
            add_reg   <= add_next;
            extra_reg <= extra_next;
            err_reg   <= err_next;
            first_reg <= first_next;
            lastn_reg <= lastn_next;
        end
    end

    always_comb begin
        g    = CNT_W'(cfg.ghost);
        g_lo = first_reg ? '0 : g;
        g_hi = lastn_reg ? g : '0;
        if (err_reg) begin
            cnt = '0;
            org = '0;
        end else begin
            cnt = CNT_W'(q_reg) + CNT_W'(extra_reg) + g_lo + g_hi;
            org = prod_reg + CNT_W'(add_reg) - g_lo;
        end
        sym_err = err_reg;
    end

endmodule

### hw/rtl/block_partition_3d_domain_split.sv
// Locates a node of a 3D block decomposition: each node_rank beat gives the
// node's x/y/z grid coordinates and, per axis, its local point count and
// origin with ghost layers. One beat is accepted per cycle while the output
// register can take one; each passes 30 cells of the rank / plane divider,
// 22 cells of the plane remainder / x_procs divider, one finishing stage and
// one output register. Per-axis point division runs in the first divider
// alongside the rank. Configuration must be written while no beat is in flight.
module block_partition_3d_domain_split
    import bp3d_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // node_rank
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // x_coord, y_coord, z_coord, x_count, y_count, z_count, x_origin,
    // y_origin, z_origin, symmetry_error, rank_out_of_range
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    typedef struct packed {
        logic                oor;
        logic [PROC_W-1:0]   zc;
        logic [PT_W-1:0]     qx, qy, qz;
        logic [PROC_W-1:0]   rx, ry, rz;
    } b_sb_t;

    logic [PROC_W-1:0] x_procs_reg, y_procs_reg, z_procs_reg;
    logic [PT_W-1:0]   x_points_reg, y_points_reg, z_points_reg;
    logic [GH_W-1:0]   ghost_reg;
    logic              sym_x_reg;

    logic [PROC_W-1:0] xp, yp, zp;
    logic [PT_W-1:0]   xpt, ypt, zpt;
    logic [PLANE_W-1:0] plane;

    logic en;

    logic                            a_vld;
    logic [3:0][RANK_W-1:0]          a_num, a_quo;
    logic [3:0][PLANE_W-1:0]         a_den, a_rem;

    b_sb_t                b_sb_in;
    b_sb_t                b_sb_reg [PLANE_W];
    logic                 b_vld;
    logic [0:0][PLANE_W-1:0] b_num, b_quo;
    logic [0:0][PROC_W-1:0]  b_den, b_rem;

    b_sb_t               bo;
    axis_cfg_t           cfg_x, cfg_y, cfg_z;
    logic [CNT_W-1:0]    cnt_x, cnt_y, cnt_z, org_x, org_y, org_z;
    logic                err_x, err_y, err_z;

    logic                c1_vld_reg, c1_oor_reg;
    logic [COORD_W-1:0]  c1_xc_reg, c1_yc_reg, c1_zc_reg;

    logic                   m_valid_reg;
    logic [OUT_TDATA_W-1:0] m_data_reg, m_data_next;

    function automatic logic [PROC_W-1:0] eff_procs(input logic [PROC_W-1:0] p);
        logic [PROC_W-1:0] res;
        if (p == '0) begin
            res = PROC_W'(1);
        end else if (32'(p) > MAX_PROCS_PER_AXIS) begin
            res = PROC_W'(MAX_PROCS_PER_AXIS);
        end else begin
            res = p;
        end
        return res;
    endfunction

    function automatic logic [PT_W-1:0] eff_points(input logic [PT_W-1:0] p);
        logic [PT_W-1:0] res;
        if (32'(p) > MAX_POINTS) begin
            res = PT_W'(MAX_POINTS);
        end else begin
            res = p;
        end
        return res;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_procs_reg  <= PROC_W'(1);
            y_procs_reg  <= PROC_W'(1);
            z_procs_reg  <= PROC_W'(1);
            x_points_reg <= PT_W'(64);
            y_points_reg <= PT_W'(64);
            z_points_reg <= PT_W'(64);
            ghost_reg    <= '0;
            sym_x_reg    <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_X_PROCS:  x_procs_reg  <= cfg_wdata[PROC_W-1:0];
                REG_Y_PROCS:  y_procs_reg  <= cfg_wdata[PROC_W-1:0];
                REG_Z_PROCS:  z_procs_reg  <= cfg_wdata[PROC_W-1:0];
                REG_X_POINTS: x_points_reg <= cfg_wdata[PT_W-1:0];
                REG_Y_POINTS: y_points_reg <= cfg_wdata[PT_W-1:0];
                REG_Z_POINTS: z_points_reg <= cfg_wdata[PT_W-1:0];
                REG_GHOST:    ghost_reg    <= cfg_wdata[GH_W-1:0];
                REG_SYM_X:    sym_x_reg    <= cfg_wdata[0];
                default:      ;
            endcase
        end
    end

    always_comb begin
        xp    = eff_procs(x_procs_reg);
        yp    = eff_procs(y_procs_reg);
        zp    = eff_procs(z_procs_reg);
        xpt   = eff_points(x_points_reg);
        ypt   = eff_points(y_points_reg);
        zpt   = eff_points(z_points_reg);
        plane = xp * yp;
    end

    // whole pipe moves whenever the output register can take a beat
    assign en       = !m_valid_reg || m_tready;
    assign s_tready = en;

    // lane 0: rank / plane, lanes 1-3: points / procs per axis
    assign a_num[0] = s_tdata[RANK_W-1:0];
    assign a_num[1] = RANK_W'(xpt);
    assign a_num[2] = RANK_W'(ypt);
    assign a_num[3] = RANK_W'(zpt);
    assign a_den[0] = plane;
    assign a_den[1] = PLANE_W'(xp);
    assign a_den[2] = PLANE_W'(yp);
    assign a_den[3] = PLANE_W'(zp);

    bp3d_divider #(.LANES(4), .NW(RANK_W), .DW(PLANE_W)) u_div_rank (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .vld_in  (s_tvalid),
        .num_in  (a_num),
        .den     (a_den),
        .vld_out (a_vld),
        .quo_out (a_quo),
        .rem_out (a_rem)
    );

    always_comb begin
        b_sb_in.oor = (a_quo[0] >= RANK_W'(zp));
        b_sb_in.zc  = a_quo[0][PROC_W-1:0];
        b_sb_in.qx  = a_quo[1][PT_W-1:0];
        b_sb_in.qy  = a_quo[2][PT_W-1:0];
        b_sb_in.qz  = a_quo[3][PT_W-1:0];
        b_sb_in.rx  = a_rem[1][PROC_W-1:0];
        b_sb_in.ry  = a_rem[2][PROC_W-1:0];
        b_sb_in.rz  = a_rem[3][PROC_W-1:0];
    end

    assign b_num[0] = a_rem[0];
    assign b_den[0] = xp;

    bp3d_divider #(.LANES(1), .NW(PLANE_W), .DW(PROC_W)) u_div_plane (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .vld_in  (a_vld),
        .num_in  (b_num),
        .den     (b_den),
        .vld_out (b_vld),
        .quo_out (b_quo),
        .rem_out (b_rem)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            b_sb_reg[0] <= b_sb_in;
            for (int k = 1; k < PLANE_W; k++) begin
                b_sb_reg[k] <= b_sb_reg[k-1];
            end
        end
    end

    assign bo = b_sb_reg[PLANE_W-1];

    assign cfg_x = '{procs: xp, ghost: ghost_reg, sym: sym_x_reg};
    assign cfg_y = '{procs: yp, ghost: ghost_reg, sym: 1'b0};
    assign cfg_z = '{procs: zp, ghost: ghost_reg, sym: 1'b0};

    bp3d_axis u_axis_x (
        .aclk (aclk), .en (en), .cfg (cfg_x),
        .q (bo.qx), .r (bo.rx), .me (b_rem[0]),
        .cnt (cnt_x), .org (org_x), .sym_err (err_x)
    );

    bp3d_axis u_axis_y (
        .aclk (aclk), .en (en), .cfg (cfg_y),
        .q (bo.qy), .r (bo.ry), .me (b_quo[0][PROC_W-1:0]),
        .cnt (cnt_y), .org (org_y), .sym_err (err_y)
    );

    bp3d_axis u_axis_z (
        .aclk (aclk), .en (en), .cfg (cfg_z),
        .q (bo.qz), .r (bo.rz), .me (bo.zc),
        .cnt (cnt_z), .org (org_z), .sym_err (err_z)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c1_vld_reg <= 1'b0;
        end else if (en) begin
            c1_vld_reg <= b_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c1_oor_reg <= bo.oor;
            c1_xc_reg  <= b_rem[0][COORD_W-1:0];
            c1_yc_reg  <= b_quo[0][COORD_W-1:0];
            c1_zc_reg  <= bo.zc[COORD_W-1:0];
        end
    end

    // y and z never raise an error; an out-of-range rank clears all but its flag
    always_comb begin
        if (c1_oor_reg) begin
            m_data_next      = '0;
            m_data_next[133] = 1'b1;
        end else begin
            m_data_next = {2'b00, 1'b0, err_x | err_y | err_z,
                           org_z, org_y, org_x, cnt_z, cnt_y, cnt_x,
                           c1_zc_reg, c1_yc_reg, c1_xc_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= c1_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

`ifndef SYNTHESIS
    a_ready_follows_out: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow output slot");

    a_oor_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[133]) |-> (m_tdata[132:0] == '0))
        else $error("out-of-range beat carries nonzero fields");

    a_sym_err_zero_x: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[132]) |-> (m_tdata[46:30] == '0 && m_tdata[97:81] == '0))
        else $error("symmetry error beat carries x count or origin");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");
`endif

endmodule
